// ----- rtl/core/bdp_pkg.sv -----
`default_nettype none

package bdp_pkg;

    // Item field widths
    localparam int PC_W     = 32;
    localparam int OFF_W    = 13;
    localparam int CTR_W    = 2;
    localparam int COUNT_W  = 32;
    localparam int MODE_W   = 2;

    // Stream word widths, padded to whole bytes
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 104;

    // Output word bit positions
    localparam int M_PRED_BIT    = 32;
    localparam int M_ACT_BIT     = 33;
    localparam int M_CORR_BIT    = 34;
    localparam int M_CTR_LSB     = 35;
    localparam int M_TOTAL_LSB   = 37;
    localparam int M_CORRECT_LSB = 69;

    // Fall-through step of a not-taken branch
    localparam logic [PC_W-1:0] FALL_STEP = PC_W'(4);

    typedef logic [PC_W-1:0]    pc_t;
    typedef logic [OFF_W-1:0]   off_t;
    typedef logic [CTR_W-1:0]   ctr_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [MODE_W-1:0]  mode_t;

    // Predictor modes
    localparam mode_t MODE_ALWAYS_TAKEN = 2'd0;
    localparam mode_t MODE_ALWAYS_NOT   = 2'd1;
    localparam mode_t MODE_ONE_BIT      = 2'd2;
    localparam mode_t MODE_TWO_BIT      = 2'd3;

    // Counter states
    localparam ctr_t CTR_STRONG_NT = 2'd0;
    localparam ctr_t CTR_STRONG_T  = 2'd3;

endpackage

`default_nettype wire

// ----- rtl/core/branch_direction_predictor.sv -----
`default_nettype none

// Channel   Dir  Handshake          Payload
// -------   ---  ---------          -------
// s_*       in   s_tvalid/s_tready  tdata: instr_pc, branch_offset; tuser: is_cond_branch
// m_*       out  m_tvalid/m_tready  tdata: resolved_pc .. correct_count
// cfg_*     in   cfg_we             cfg_wdata: predictor_mode
//
// One instruction word per cycle sustained, outside the sweep and stalls. A word
// waits in the input register (counter table read lands there), then resolves the pending
// branch in one pass of compare/update logic into the result register.
// The table has a single write port shared by the update and the clear sweep.
// After reset the whole table is swept to zero, entry by entry; s_tready
// stays low during the sweep. A stall on m_tready holds the result word and
// backs up into s_tready only when a branch is waiting to be resolved.
// A change of predictor_mode takes a reset to start from a clean table.
module branch_direction_predictor
    import bdp_pkg::*;
#(
    // Power of two
    parameter int TABLE_ENTRIES = 1024
)
(
    input  wire                 clk,
    input  wire                 rst_n,

    input  wire                 cfg_we,
    input  wire  [MODE_W-1:0]   cfg_wdata,      // predictor_mode

    input  wire                 s_tvalid,
    output logic                s_tready,
    // [31:0] instr_pc, [44:32] branch_offset, [47:45] zero
    input  wire  [S_DATA_W-1:0] s_tdata,
    // [0] is_cond_branch
    input  wire                 s_tuser,

    output logic                m_tvalid,
    input  wire                 m_tready,
    // [31:0] resolved_pc, [32] predicted_taken, [33] actual_taken,
    // [34] was_correct, [36:35] counter_state, [68:37] total_count,
    // [100:69] correct_count, [103:101] zero
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    // Counter table, one 2-bit counter per entry
    ctr_t mem [0:TABLE_ENTRIES-1];

    // Clear sweep after reset
    logic             clr_reg;
    logic [IDX_W-1:0] clr_idx_reg;

    mode_t            mode_reg;

    // Input register
    logic             in_valid_reg;
    pc_t              in_pc_reg;
    logic             in_br_reg;
    off_t             in_off_reg;
    ctr_t             in_ctr_reg;

    // Branch waiting for its successor
    logic             pend_valid_reg;
    pc_t              pend_pc_reg;
    off_t             pend_off_reg;
    ctr_t             pend_ctr_reg;

    count_t           total_reg;
    count_t           correct_reg;

    // Result register
    logic             m_valid_reg;
    pc_t              out_pc_reg;
    logic             out_pred_reg;
    logic             out_act_reg;
    logic             out_corr_reg;
    ctr_t             out_ctr_reg;

    logic             s_accept;
    logic             advance;
    logic             emit;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] pend_idx;
    logic [IDX_W-1:0] in_idx;

    ctr_t             ctr_used;
    logic             pred;
    logic             correct;
    logic             actual;
    ctr_t             ctr_new;
    logic             upd_we;
    pc_t              target;
    pc_t              fall;

    logic             mem_we;
    logic [IDX_W-1:0] mem_widx;
    ctr_t             mem_wdata;

    count_t           total_next;
    count_t           correct_next;
    logic             m_valid_next;

    // ---------------------------------------------------------------
    // Handshake: advance the input register whenever the result slot
    // is free or the word in it carries no result.
    // ---------------------------------------------------------------
    assign advance  = in_valid_reg && (!pend_valid_reg || !m_valid_reg || m_tready);
    assign emit     = advance && pend_valid_reg;
    assign s_tready = !clr_reg && (!in_valid_reg || advance);
    assign s_accept = s_tvalid && s_tready;

    assign rd_idx   = s_tdata[IDX_W+1:2];
    assign pend_idx = pend_pc_reg[IDX_W+1:2];
    assign in_idx   = in_pc_reg[IDX_W+1:2];

    // ---------------------------------------------------------------
    // Resolve the pending branch against the PC now in the input register
    // ---------------------------------------------------------------
    always_comb
    begin
        case (mode_reg)
            MODE_ALWAYS_TAKEN: ctr_used = CTR_STRONG_T;
            MODE_ALWAYS_NOT:   ctr_used = CTR_STRONG_NT;
            default:           ctr_used = pend_ctr_reg;
        endcase
    end

    assign pred    = ctr_used[1];
    assign target  = pend_pc_reg + {{(PC_W-OFF_W){pend_off_reg[OFF_W-1]}}, pend_off_reg};
    assign fall    = pend_pc_reg + FALL_STEP;
    assign correct = pred ? (target == in_pc_reg) : (fall == in_pc_reg);
    assign actual  = pred ? correct : !correct;

    // Fixed modes leave the table untouched
    assign upd_we  = emit && (mode_reg == MODE_ONE_BIT || mode_reg == MODE_TWO_BIT);

    always_comb
    begin
        ctr_new = ctr_used;
        case (mode_reg)
            MODE_ONE_BIT:
            begin
                ctr_new = actual ? CTR_STRONG_T : CTR_STRONG_NT;
            end
            MODE_TWO_BIT:
            begin
                if (actual && ctr_used != CTR_STRONG_T)
                begin
                    ctr_new = ctr_used + 2'd1;
                end
                else if (!actual && ctr_used != CTR_STRONG_NT)
                begin
                    ctr_new = ctr_used - 2'd1;
                end
            end
            default:
            begin
                ctr_new = ctr_used;
            end
        endcase
    end

    assign total_next   = (&total_reg) ? total_reg : total_reg + 1'b1;
    assign correct_next = (correct && !(&correct_reg)) ? correct_reg + 1'b1 : correct_reg;

    // ---------------------------------------------------------------
    // Counter table: single write port, registered read at accept.
    // Forward a same-cycle update to the read; an update made as the
    // word moves on to the pending register is forwarded there too.
    // ---------------------------------------------------------------
    assign mem_we    = clr_reg || upd_we;
    assign mem_widx  = clr_reg ? clr_idx_reg : pend_idx;
    assign mem_wdata = clr_reg ? CTR_STRONG_NT : ctr_new;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_widx] <= mem_wdata;
        end
        if (s_accept)
        begin
            if (upd_we && pend_idx == rd_idx)
            begin
                in_ctr_reg <= ctr_new;
            end
            else
            begin
                in_ctr_reg <= mem[rd_idx];
            end
        end
    end

    // Sweep the table to zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= 1'b1;
            clr_idx_reg <= '0;
        end
        else if (clr_reg)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (&clr_idx_reg)
            begin
                clr_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_TWO_BIT;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    assign m_valid_next = emit ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            total_reg      <= '0;
            correct_reg    <= '0;
        end
        else
        begin
            if (s_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                pend_valid_reg <= in_br_reg;
            end
            if (emit)
            begin
                total_reg   <= total_next;
                correct_reg <= correct_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    // ---------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_pc_reg  <= s_tdata[PC_W-1:0];
            in_off_reg <= s_tdata[PC_W+OFF_W-1:PC_W];
            in_br_reg  <= s_tuser;
        end
        // Non-branch words leave the pending payload alone
        if (advance && in_br_reg)
        begin
            pend_pc_reg  <= in_pc_reg;
            pend_off_reg <= in_off_reg;
            if (upd_we && pend_idx == in_idx)
            begin
                pend_ctr_reg <= ctr_new;
            end
            else
            begin
                pend_ctr_reg <= in_ctr_reg;
            end
        end
        if (emit)
        begin
            out_pc_reg   <= pend_pc_reg;
            out_pred_reg <= pred;
            out_act_reg  <= actual;
            out_corr_reg <= correct;
            out_ctr_reg  <= ctr_used;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, correct_reg, total_reg, out_ctr_reg,
                       out_corr_reg, out_act_reg, out_pred_reg, out_pc_reg};

endmodule

`default_nettype wire

// ----- rtl/core/bdp_checker.sv -----
`default_nettype none

module bdp_checker
    import bdp_pkg::*;
(
    input wire                clk,
    input wire                rst_n,
    input wire                m_tvalid,
    input wire                m_tready,
    input wire [M_DATA_W-1:0] m_tdata
);

    // Stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // Correct predictions never outnumber resolved branches
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[M_CORRECT_LSB +: COUNT_W] <= m_tdata[M_TOTAL_LSB +: COUNT_W])
        else $error("correct_count above total_count");

    // A result word always counts at least itself
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[M_TOTAL_LSB +: COUNT_W] != '0)
        else $error("result word with zero total_count");

    // Outcome follows prediction and correctness
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[M_ACT_BIT] == !(m_tdata[M_PRED_BIT] ^ m_tdata[M_CORR_BIT]))
        else $error("actual_taken inconsistent");

    // Prediction is the upper counter bit
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[M_PRED_BIT] == m_tdata[M_CTR_LSB+1])
        else $error("predicted_taken disagrees with counter_state");

endmodule

bind branch_direction_predictor bdp_checker u_bdp_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- sim/tb_branch_direction_predictor.sv -----
`timescale 1ns / 1ps

module tb_branch_direction_predictor;
    import bdp_pkg::*;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int LONG_HOLD     = 300;

    // One resolved branch as it appears on the master side
    typedef struct packed {
        pc_t    pc;
        logic   predicted;
        logic   actual;
        logic   correct;
        ctr_t   state;
        count_t total;
        count_t correct_n;
    } resolution_t;

    // Sign-extend a branch offset to PC width; the add then wraps at PC_W bits
    function automatic pc_t widen_offset(input off_t off);
        return {{(PC_W - OFF_W){off[OFF_W-1]}}, off};
    endfunction

    // Scoreboard: shadow copy of the predictor state, fed with every accepted
    // instruction word, holding the resolutions still owed by the block.
    class resolution_scoreboard;
        mode_t       mode;
        logic        branch_pending;
        pc_t         branch_pc;
        off_t        branch_off;
        logic        entry_written [TABLE_ENTRIES];
        ctr_t        counter_bits [TABLE_ENTRIES];
        count_t      resolved_n;
        count_t      correct_n;
        resolution_t expected_resolutions [$];
        int          errors;

        function new();
            mode           = MODE_TWO_BIT;
            branch_pending = 1'b0;
            branch_pc      = '0;
            branch_off     = '0;
            resolved_n     = '0;
            correct_n      = '0;
            errors         = 0;
            foreach (entry_written[i])
            begin
                entry_written[i] = 1'b0;
                counter_bits[i]  = CTR_STRONG_NT;
            end
        endfunction

        function void set_mode(input mode_t m);
            mode = m;
        endfunction

        function int outstanding();
            return expected_resolutions.size();
        endfunction

        // Resolve the waiting branch against this PC, then latch this word
        // if it is itself a branch.
        function void note_instruction(input pc_t pc, input logic is_branch, input off_t off);
            logic [IDX_W-1:0] idx;
            ctr_t             used;
            ctr_t             next_state;
            logic             pred;
            logic             hit;
            logic             taken;
            resolution_t      r;

            if (branch_pending)
            begin
                idx  = branch_pc[2 +: IDX_W];
                used = entry_written[idx] ? counter_bits[idx] : CTR_STRONG_NT;
                if (mode == MODE_ALWAYS_TAKEN)
                    used = CTR_STRONG_T;
                else if (mode == MODE_ALWAYS_NOT)
                    used = CTR_STRONG_NT;
                pred = used[1];

                if (pred)
                    hit = (branch_pc + widen_offset(branch_off)) == pc;
                else
                    hit = (branch_pc + FALL_STEP) == pc;
                // Outcome follows the PC actually reached
                taken = pred ? hit : !hit;

                if (mode == MODE_ONE_BIT)
                begin
                    counter_bits[idx]  = taken ? CTR_STRONG_T : CTR_STRONG_NT;
                    entry_written[idx] = 1'b1;
                end
                else if (mode == MODE_TWO_BIT)
                begin
                    next_state = used;
                    if (taken && used != CTR_STRONG_T)
                        next_state = used + 1'b1;
                    else if (!taken && used != CTR_STRONG_NT)
                        next_state = used - 1'b1;
                    counter_bits[idx]  = next_state;
                    entry_written[idx] = 1'b1;
                end

                if (resolved_n != '1)
                    resolved_n++;
                if (hit && correct_n != '1)
                    correct_n++;

                r.pc        = branch_pc;
                r.predicted = pred;
                r.actual    = taken;
                r.correct   = hit;
                r.state     = used;
                r.total     = resolved_n;
                r.correct_n = correct_n;
                expected_resolutions = {expected_resolutions, r};
            end

            if (is_branch)
            begin
                branch_pc  = pc;
                branch_off = off;
            end
            branch_pending = is_branch;
        endfunction

        function void compare_field(input string name, input longint unsigned want,
                                    input longint unsigned got);
            if (want != got)
            begin
                $error("%s mismatch: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_resolution(input logic [M_DATA_W-1:0] word);
            resolution_t want;

            if (expected_resolutions.size() == 0)
            begin
                $error("result word %h with no branch awaiting resolution", word);
                errors++;
                return;
            end
            want = expected_resolutions.pop_front();
            compare_field("resolved_pc", want.pc, word[PC_W-1:0]);
            compare_field("predicted_taken", want.predicted, word[M_PRED_BIT]);
            compare_field("actual_taken", want.actual, word[M_ACT_BIT]);
            compare_field("was_correct", want.correct, word[M_CORR_BIT]);
            compare_field("counter_state", want.state, word[M_CTR_LSB +: CTR_W]);
            compare_field("total_count", want.total, word[M_TOTAL_LSB +: COUNT_W]);
            compare_field("correct_count", want.correct_n, word[M_CORRECT_LSB +: COUNT_W]);
        endfunction
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [MODE_W-1:0]   cfg_wdata = MODE_TWO_BIT;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic                s_tuser   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    resolution_scoreboard sb = new();

    // Burst flags flip now and then so that gap-free stretches mix with idling
    bit sender_burst = 1'b0;
    bit sink_burst   = 1'b0;
    // Long receiver stall requested by the main sequence, served by the sink
    int hold_request = 0;
    int cycle_count  = 0;

    branch_direction_predictor #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one instruction word and hold it until the block takes it.
    // Entered and left at a rising edge; tvalid stays high on exit so a
    // back-to-back word needs no second assignment in the same step.
    task automatic send_word(input pc_t pc, input logic is_branch, input off_t off);
        int gap;

        if ($urandom_range(0, 29) == 0)
            sender_burst = !sender_burst;
        gap = sender_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= is_branch;
        s_tdata  <= {{(S_DATA_W - PC_W - OFF_W){1'b0}}, off, pc};
        // Sample tready as it stood at the edge
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_instruction(pc, is_branch, off);
    endtask

    // Write the mode register; only called while the block is idle
    task automatic write_mode(input mode_t m);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_mode(m);
    endtask

    // Drop tvalid, wait for every owed resolution, then let the pipe empty
    task automatic drain_block();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Corners: wrap of target and fall-through, offset extremes, offset equal
    // to the fall-through step, counter saturation both ways, aliasing of two
    // PCs on one table entry, never-written entries, an all-ones PC.
    task automatic run_corners();
        send_word(32'h0000_0100, 1'b1, 13'd16);
        send_word(32'h0000_0104, 1'b1, 13'h1000);
        send_word(32'hFFFF_F104, 1'b0, 13'h0FFF);
        send_word(32'hFFFF_FFFC, 1'b1, 13'h0FFF);
        send_word(32'h0000_0000, 1'b1, 13'h1FFC);
        send_word(32'hFFFF_FFFC, 1'b1, 13'd4);
        send_word(32'h0000_0000, 1'b0, 13'd0);
        // Train one branch taken until the counter saturates, then miss it
        repeat (4)
        begin
            send_word(32'h0000_0104, 1'b1, 13'h0FFF);
            send_word(32'h0000_1103, 1'b0, 13'd0);
        end
        send_word(32'h0000_0104, 1'b1, 13'h0FFF);
        send_word(32'h0000_0108, 1'b0, 13'd0);
        // Alias of the entry just trained
        send_word(32'h0000_1104, 1'b1, 13'd0);
        send_word(32'h0000_1108, 1'b0, 13'd0);
        send_word(32'hFFFF_FFFF, 1'b1, 13'h1FFF);
        send_word(32'hFFFF_FFFE, 1'b0, 13'd0);
    endtask

    // Random trace: a small set of branch sites, most with a preferred
    // direction, so the counters really learn; some sites alias others.
    // Resolving words mostly land on target or fall-through, a few elsewhere.
    task automatic run_trace(input int n_words);
        pc_t  site_pc   [8];
        off_t site_off  [8];
        int   site_bias [8];
        pc_t  pc;
        pc_t  last_pc;
        off_t off;
        off_t last_off;
        logic is_branch;
        logic last_branch;
        int   last_site;
        int   k;
        int   pick;

        for (int i = 0; i < 8; i++)
        begin
            site_pc[i]   = $urandom();
            site_off[i]  = off_t'($urandom());
            site_bias[i] = (i % 3 == 0) ? 5 : ((i % 3 == 1) ? 95 : 50);
            if (i >= 4)
                site_pc[i][IDX_W+1:0] = site_pc[i-4][IDX_W+1:0];
        end
        last_branch = 1'b0;
        last_site   = -1;
        last_pc     = '0;
        last_off    = '0;

        for (int n = 0; n < n_words; n++)
        begin
            pick = $urandom_range(0, 99);
            k    = -1;
            if (last_branch)
            begin
                if (pick < 8)
                    pc = $urandom();
                else if ($urandom_range(0, 99) < ((last_site >= 0) ? site_bias[last_site] : 50))
                    pc = last_pc + widen_offset(last_off);
                else
                    pc = last_pc + FALL_STEP;
                is_branch = ($urandom_range(0, 3) == 0);
                off       = off_t'($urandom());
            end
            else if (pick < 80)
            begin
                k         = $urandom_range(0, 7);
                pc        = site_pc[k];
                off       = ($urandom_range(0, 9) == 0) ? off_t'($urandom()) : site_off[k];
                is_branch = 1'b1;
            end
            else
            begin
                pc        = $urandom();
                off       = off_t'($urandom());
                is_branch = ($urandom_range(0, 1) == 1);
            end
            // Close the phase with nothing left to resolve
            if (n == n_words - 1)
                is_branch = 1'b0;
            send_word(pc, is_branch, off);
            last_branch = is_branch;
            last_site   = k;
            last_pc     = pc;
            last_off    = off;
        end
    endtask

    // Receiver: random tready gaps per word, plus one long stall on request
    initial
    begin
        int gap;

        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 29) == 0)
                sink_burst = !sink_burst;
            gap = sink_burst ? 0 : $urandom_range(0, 13);
            // A requested long stall stretches this gap
            if (hold_request > 0)
            begin
                gap          = gap + hold_request;
                hold_request = 0;
            end
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            sb.check_resolution(m_tdata);
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("branch_direction_predictor test failed");
        $finish;
    end

    // Main sequence: one phase per plan entry, each mode at least once, extremes included;
    // the table carries over between phases since reset is never repeated.
    initial
    begin
        mode_t plan [6];

        plan = '{MODE_TWO_BIT, MODE_ONE_BIT, MODE_ALWAYS_TAKEN,
                 MODE_ALWAYS_NOT, MODE_ONE_BIT, MODE_TWO_BIT};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        // The clearing sweep runs now; send_word waits it out on tready

        for (int p = 0; p < 6; p++)
        begin
            write_mode(plan[p]);
            if (p == 0)
                run_corners();
            // Stall the receiver long enough to back up into s_tready
            if (p == 2)
                hold_request = LONG_HOLD;
            run_trace((p == 0) ? 205 : 229);
            drain_block();
        end

        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("branch_direction_predictor test passed");
        else
            $display("branch_direction_predictor test failed");
        $finish;
    end

endmodule
